// ===== rtl/hs_pkg.sv =====
// hs_pkg: shared types, constants and helpers for the hmac-sha1 engine
// no dependencies; imported by every module of the block
package hs_pkg;

  localparam int BLOCK_BYTES   = 64;
  localparam int KEY_WORDS     = 8;
  localparam int QUEUE_DEPTH_D = 4;
  localparam int ROUNDS        = 80;

  localparam logic [7:0]  IPAD_BYTE = 8'h36;
  localparam logic [7:0]  OPAD_BYTE = 8'h5C;
  localparam logic [31:0] OUTER_BITS = 32'((BLOCK_BYTES + 20) * 8);

  typedef logic [4:0][31:0]          hash_t;
  typedef logic [15:0][31:0]         block_t;
  typedef logic [KEY_WORDS-1:0][63:0] key_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // request handed from front to back
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } cmd_t;

  localparam hash_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  function automatic block_t pad_block(input key_t key, input logic [7:0] pad);
    block_t b;
    for (int i = 0; i < KEY_WORDS; i++) begin
      b[2*i]   = key[i][63:32] ^ {4{pad}};
      b[2*i+1] = key[i][31:0]  ^ {4{pad}};
    end
    return b;
  endfunction

endpackage

// ===== rtl/hs_front.sv =====
// hs_front: accepts input requests, drops idle ones, queues the rest
// depends on hs_pkg
module hs_front import hs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output cmd_t     cmd,
  input  logic     cmd_pop
);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  in_item_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              push, pop;

  assign in_ready = (count != CW'(QUEUE_DEPTH));
  // idle requests carry nothing and are not queued
  assign push = in_valid && in_ready && (in_item.has_byte || in_item.is_last);
  assign pop  = cmd_pop && (count != '0);

  assign cmd.valid = (count != '0);
  assign cmd.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hs_core.sv =====
// hs_core: sha-1 compression, one round per clock, 16-word schedule window
// depends on hs_pkg
module hs_core import hs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  block_t blk,
  input  hash_t  h_in,
  output logic   done,
  output hash_t  h_out
);
  logic [31:0] a, b, c, d, e;
  logic [15:0][31:0] w;
  hash_t       h_save;
  logic [6:0]  rnd;
  logic        busy, fin;
  logic [31:0] f, k, t, w_new;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d;
      k = 32'hCA62C1D6;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w[0];
    w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      {e, d, c, b, a} <= h_in;
      h_save <= h_in;
      w      <= blk;
    end else if (busy) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
      w <= {w_new, w[15:1]};
    end
    if (fin) begin
      h_out[0] <= h_save[0] + a;
      h_out[1] <= h_save[1] + b;
      h_out[2] <= h_save[2] + c;
      h_out[3] <= h_save[3] + d;
      h_out[4] <= h_save[4] + e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
        if (rnd == 7'(ROUNDS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/hs_back.sv =====
// hs_back: message sequencer; buffers bytes, pads, runs inner and outer hashes
// depends on hs_pkg and hs_core
module hs_back import hs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  key_t      key,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);
  localparam logic [3:0] S_IDLE = 4'd0, S_PROC = 4'd1, S_BCOMP = 4'd2,
                         S_PAD = 4'd3, S_PCOMP = 4'd4, S_LEN = 4'd5,
                         S_LCOMP = 4'd6, S_OCOMP = 4'd7, S_FCOMP = 4'd8,
                         S_WAIT = 4'd9, S_OUT = 4'd10, S_ICOMP = 4'd11;

  logic [3:0]  state, ret;
  in_item_t    cur;
  block_t      buffer;
  hash_t       chain, inner, res;
  logic [63:0] byte_count;
  logic        started;
  logic [5:0]  pad_pos;
  logic        pad_first;
  logic [2:0]  out_cnt;
  logic [63:0] bits;

  logic        core_start, core_done;
  block_t      core_blk, fin_blk;
  hash_t       core_h, core_out;

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_val;

  hs_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .blk(core_blk),
    .h_in(core_h), .done(core_done), .h_out(core_out)
  );

  assign bits = {byte_count[60:0] + 61'd64, 3'b000};

  always_comb begin
    fin_blk     = '0;
    fin_blk[0]  = inner[0];
    fin_blk[1]  = inner[1];
    fin_blk[2]  = inner[2];
    fin_blk[3]  = inner[3];
    fin_blk[4]  = inner[4];
    fin_blk[5]  = 32'h80000000;
    fin_blk[15] = OUTER_BITS;
  end

  always_comb begin
    core_start = 1'b0;
    core_blk   = buffer;
    core_h     = chain;
    case (state)
      S_ICOMP: begin
        core_start = 1'b1;
        core_blk   = pad_block(key, IPAD_BYTE);
        core_h     = SHA1_IV;
      end
      S_BCOMP, S_PCOMP, S_LCOMP: core_start = 1'b1;
      S_OCOMP: begin
        core_start = 1'b1;
        core_blk   = pad_block(key, OPAD_BYTE);
        core_h     = SHA1_IV;
      end
      S_FCOMP: begin
        core_start = 1'b1;
        core_blk   = fin_blk;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_pos = byte_count[5:0];
    wr_val = cur.data_byte;
    if (state == S_PROC && cur.has_byte) begin
      wr_en = 1'b1;
    end else if (state == S_PAD) begin
      wr_en  = 1'b1;
      wr_pos = pad_pos;
      wr_val = pad_first ? 8'h80 : 8'h00;
    end
  end

  assign cmd_pop = (state == S_IDLE);

  // byte lane write; the first byte of a word clears the rest of it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_pos[1:0])
        2'd0: buffer[wr_pos[5:2]] <= {wr_val, 24'h0};
        2'd1: buffer[wr_pos[5:2]][23:16] <= wr_val;
        2'd2: buffer[wr_pos[5:2]][15:8]  <= wr_val;
        2'd3: buffer[wr_pos[5:2]][7:0]   <= wr_val;
        default: ;
      endcase
    end else if (state == S_LEN) begin
      buffer[14] <= bits[63:32];
      buffer[15] <= bits[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid) begin
      cur <= cmd.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      started    <= 1'b0;
      byte_count <= '0;
      pad_pos    <= '0;
      pad_first  <= 1'b0;
      out_cnt    <= '0;
      chain      <= SHA1_IV;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            state <= started ? S_PROC : S_ICOMP;
          end
        end
        S_ICOMP: begin
          ret   <= S_ICOMP;
          state <= S_WAIT;
        end
        S_PROC: begin
          pad_first <= 1'b1;
          if (cur.has_byte) begin
            byte_count <= byte_count + 64'd1;
            pad_pos    <= byte_count[5:0] + 6'd1;
            if (byte_count[5:0] == 6'(BLOCK_BYTES - 1)) begin
              state <= S_BCOMP;
            end else begin
              state <= cur.is_last ? S_PAD : S_IDLE;
            end
          end else begin
            pad_pos <= byte_count[5:0];
            state   <= S_PAD;
          end
        end
        S_BCOMP: begin
          ret   <= S_BCOMP;
          state <= S_WAIT;
        end
        S_PAD: begin
          pad_first <= 1'b0;
          pad_pos   <= pad_pos + 6'd1;
          if (pad_pos == 6'(BLOCK_BYTES - 1)) begin
            state <= S_PCOMP;
          end else if (pad_pos == 6'(BLOCK_BYTES - 9)) begin
            state <= S_LEN;
          end
        end
        S_PCOMP: begin
          ret   <= S_PCOMP;
          state <= S_WAIT;
        end
        S_LEN:   state <= S_LCOMP;
        S_LCOMP: begin
          ret   <= S_LCOMP;
          state <= S_WAIT;
        end
        S_OCOMP: begin
          ret   <= S_OCOMP;
          state <= S_WAIT;
        end
        S_FCOMP: begin
          ret   <= S_FCOMP;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (core_done) begin
            chain <= core_out;
            case (ret)
              S_ICOMP: begin
                started    <= 1'b1;
                byte_count <= '0;
                state      <= S_PROC;
              end
              S_BCOMP: state <= cur.is_last ? S_PAD : S_IDLE;
              S_PCOMP: state <= S_PAD;
              S_LCOMP: begin
                inner <= core_out;
                state <= S_OCOMP;
              end
              S_OCOMP: state <= S_FCOMP;
              S_FCOMP: begin
                res     <= core_out;
                out_cnt <= '0;
                state   <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_cnt <= out_cnt + 3'd1;
            if (out_cnt == 3'd4) begin
              started    <= 1'b0;
              byte_count <= '0;
              chain      <= SHA1_IV;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = (state == S_OUT);
  assign out_item.digest_word = res[out_cnt];
  assign out_item.word_index  = out_cnt;
  assign out_item.last_word   = (out_cnt == 3'd4);

  a_out_started: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> started)
    else $error("digest shown without an open message");
  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    core_done |-> state == S_WAIT)
    else $error("compression finished with nobody waiting");
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_cnt == 3'd4) |=> (!started && byte_count == '0))
    else $error("message state not cleared after digest");

endmodule

// ===== rtl/hmac_sha1_engine.sv =====
// hmac-sha1 engine: bytes in, five digest words out per message
// a message byte is popped in the back end's idle state and absorbed in its proc state;
// every 64th byte adds a compression (one round per cycle in the shared sha-1 core)
// message start costs one extra compression; the last request adds 3 to 4 more compressions
// plus padding bytes before the five words appear, one per cycle while out_ready is high
// synchronous active-high reset clears key registers, queue and message state
module hmac_sha1_engine import hs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  // key registers, word i holds key bytes 8i..8i+7 big-endian
  key_t key;
  cmd_t cmd;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end

  // front: takes requests, drops idle ones, buffers the rest
  hs_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  // back: block assembly, padding, inner and outer hash, digest output
  hs_back u_back (
    .clk(clk), .rst(rst), .key(key), .cmd(cmd), .cmd_pop(cmd_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

endmodule

// ===== bench/hmac_sha1_engine_tb.sv =====
// hmac_sha1_engine_tb: self-checking bench for the hmac-sha1 engine
// streams byte requests, predicts the five digest words per message, compares each one
// depends on hs_pkg (item types) and the hmac_sha1_engine rtl
module hmac_sha1_engine_tb;
  import hs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 600;

  typedef logic [31:0] word_t;
  typedef word_t chain_t[5];
  typedef word_t blk_t[16];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  always #4 clk = ~clk;

  hmac_sha1_engine u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state: key copy plus running inner hash
  logic [63:0] key_copy[8];
  chain_t hash_state;
  blk_t msg_block;
  logic [63:0] msg_len;
  bit msg_open;

  out_item_t digest_q[$];
  int mismatches = 0;
  int words_seen = 0;
  int messages_sent = 0;
  longint cycles = 0;
  bit quiet = 1'b0;           // no stalls in the closing stretch

  function automatic word_t rotl(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_round_block(ref chain_t h, input blk_t b);
    word_t w[80];
    word_t a, bb, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = b[i];
    for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[0]; bb = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (bb & c) | (~bb & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = bb ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (bb & c) | (bb & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = bb ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(bb, 30); bb = a; a = t;
    end
    h[0] += a; h[1] += bb; h[2] += c; h[3] += d; h[4] += e;
  endfunction

  function automatic void load_iv(ref chain_t h);
    h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
    h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
  endfunction

  function automatic blk_t keyed_block(word_t pad);
    blk_t b;
    for (int i = 0; i < 8; i++) begin
      b[2*i] = key_copy[i][63:32] ^ pad;
      b[2*i+1] = key_copy[i][31:0] ^ pad;
    end
    return b;
  endfunction

  function automatic void store_byte(int pos, logic [7:0] v);
    if (pos % 4 == 0) msg_block[pos/4] = {v, 24'h0};
    else msg_block[pos/4][(3 - pos % 4)*8 +: 8] = v;
  endfunction

  // advance the hmac predictor by one request; queue digest words on a last request
  function automatic void hmac_predict(in_item_t it);
    int pos;
    logic [63:0] bits;
    chain_t inner;
    blk_t ob;
    if (!it.has_byte && !it.is_last) return;
    if (!msg_open) begin
      load_iv(hash_state);
      sha1_round_block(hash_state, keyed_block({4{IPAD_BYTE}}));
      msg_open = 1'b1;
      msg_len = '0;
    end
    if (it.has_byte) begin
      pos = int'(msg_len[5:0]);
      store_byte(pos, it.data_byte);
      msg_len++;
      if (pos == 63) sha1_round_block(hash_state, msg_block);
    end
    if (!it.is_last) return;
    pos = int'(msg_len[5:0]);
    store_byte(pos, 8'h80);
    for (int p = pos + 1; p < 64; p++) store_byte(p, 8'h00);
    if (pos >= 56) begin
      sha1_round_block(hash_state, msg_block);
      foreach (msg_block[i]) msg_block[i] = '0;
    end
    bits = (msg_len + 64) * 8;
    msg_block[14] = bits[63:32];
    msg_block[15] = bits[31:0];
    sha1_round_block(hash_state, msg_block);
    inner = hash_state;
    load_iv(hash_state);
    sha1_round_block(hash_state, keyed_block({4{OPAD_BYTE}}));
    foreach (ob[i]) ob[i] = '0;
    for (int i = 0; i < 5; i++) ob[i] = inner[i];
    ob[5] = 32'h80000000;
    ob[15] = OUTER_BITS;
    sha1_round_block(hash_state, ob);
    for (int i = 0; i < 5; i++)
      digest_q.push_back('{digest_word: hash_state[i], word_index: 3'(i),
                           last_word: (i == 4)});
    load_iv(hash_state);
    msg_open = 1'b0;
    msg_len = '0;
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receive side: random stall bursts, compare each accepted word
  initial begin
    int stall;
    out_item_t want;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        words_seen++;
        if (digest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected digest word %h", out_item);
        end else begin
          want = digest_q.pop_front();
          if (out_item !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: got word %h idx %0d last %b, want %h idx %0d last %b",
                       out_item.digest_word, out_item.word_index, out_item.last_word,
                       want.digest_word, want.word_index, want.last_word);
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // send one request: optional idle gap, then hold valid until accepted
  // valid stays up afterwards so the next request can follow with no gap
  task automatic send_req(in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    hmac_predict(it);
    if (it.is_last) messages_sent++;
  endtask

  task automatic write_key(int idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= 3'(idx);
    cfg_data <= v;
    key_copy[idx] = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // sender drops valid and waits until every digest word is back, then waits out the DRAIN_CYCLES stretch
  task automatic drain();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_message(int len, bit mostly_tail_last);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = 8'($urandom);
      it.has_byte = 1'b1;
      it.is_last = (i == len - 1) && mostly_tail_last;
      send_req(it);
      if ($urandom_range(0, 15) == 0) begin
        it = '{data_byte: 8'($urandom), has_byte: 1'b0, is_last: 1'b0};
        send_req(it);
      end
    end
    if (!mostly_tail_last || len == 0) begin
      it = '{data_byte: 8'($urandom), has_byte: 1'b0, is_last: 1'b1};
      send_req(it);
    end
  endtask

  // directed requests; fixed rows check the known empty-key empty-message digest
  typedef struct {
    in_item_t it;
    bit fixed;
    word_t w0;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, 32'hFBDB1D1B},  // empty message, all-zero key
    '{'{8'hA5, 1'b0, 1'b0}, 1'b0, '0},            // idle request, nothing happens
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b1, 1'b1}, 1'b0, '0},            // byte together with last
    '{'{8'hFF, 1'b1, 1'b1}, 1'b0, '0},            // single byte message
    '{'{8'h5A, 1'b0, 1'b1}, 1'b0, '0}
  };

  initial begin
    in_item_t it;
    int n;
    foreach (key_copy[i]) key_copy[i] = '0;
    load_iv(hash_state);
    foreach (msg_block[i]) msg_block[i] = '0;
    msg_len = '0;
    msg_open = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset key
    foreach (dir_rows[r]) begin
      send_req(dir_rows[r].it);
      if (dir_rows[r].fixed) begin
        if (digest_q[0].digest_word !== dir_rows[r].w0) begin
          mismatches++;
          $display("predictor disagrees with known digest: %h", digest_q[0].digest_word);
        end
      end
    end
    drain();

    // all-ones key, block boundary lengths 55, 56, 63, 64
    for (int i = 0; i < 8; i++) write_key(i, '1);
    for (int j = 0; j < 4; j++)
      send_message(j == 0 ? 55 : j == 1 ? 56 : j == 2 ? 63 : 64, 1);
    drain();

    // key change inside a message: inner uses old key, outer uses new
    send_message(3, 0);
    drain();
    it = '{8'h11, 1'b1, 1'b0};
    send_req(it);
    drain();
    write_key(3, 64'h0123456789ABCDEF);   // engine idle between requests
    it = '{8'h22, 1'b1, 1'b1};
    send_req(it);
    drain();

    // random part: random keys per phase, mostly short messages
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 8; i++) write_key(i, {$urandom, $urandom});
      if (ph == 5) quiet = 1'b1;
      for (int m = 0; m < 2; m++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 12);
        send_message(n, $urandom_range(0, 1));
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d messages, %0d digest words checked", messages_sent, words_seen);
    $display("keys: reset, all-ones, mid-message change and six random settings");
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, digest_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
